[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the load-cell conditioner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lcat_pkg.sv]
// ----------------------------------------------------------------------------
// lcat_pkg
// Widths, codes and shared types of the load-cell average/tare/calibrate block.
// ----------------------------------------------------------------------------
package lcat_pkg;

    // Sample window.
    localparam int SAMPLES     = 16;
    localparam int IDX_W       = $clog2(SAMPLES);
    localparam int FILL_W      = $clog2(SAMPLES + 1);

    // Field widths.
    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = SAMPLE_W + IDX_W;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int FACTOR_W    = 32;
    localparam int MASS_W      = 24;
    localparam int WEIGHT_W    = 32;
    localparam int ACTION_W    = 2;

    // Fixed-point scaling of weight and factor (2^24 = Q.8 times Q.16).
    localparam int SCALE_SHIFT = 24;

    // Serial divider sizing.
    localparam int NUM_W       = SAMPLE_W + SCALE_SHIFT;
    localparam int DEN_W       = FACTOR_W;
    localparam int CNT_W       = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] AVG_STEPS = CNT_W'(SUM_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

    // Constants.
    localparam logic [FACTOR_W-1:0] DEFAULT_FACTOR = FACTOR_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = {1'b0, {(WEIGHT_W - 1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN     = {1'b1, {(WEIGHT_W - 1){1'b0}}};
    localparam logic [FACTOR_W-1:0] FACTOR_MAX     = {FACTOR_W{1'b1}};

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TARE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CALIB  = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Request to the serial divider.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    // Response from the serial divider.
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

    // Status of the sample ring.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [FILL_W-1:0]       fill;
    } ring_stat_t;

endpackage

[hdl/lcat_if.sv]
// ----------------------------------------------------------------------------
// lcat channel interfaces
// Valid/ready channels for input items, results and the factor register.
// ----------------------------------------------------------------------------

// Input item channel.
interface lcat_in_if
    import lcat_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    sample_t             raw_sample;
    logic [MASS_W-1:0]   known_grams;

    modport source (output valid, action, raw_sample, known_grams, input ready);
    modport sink   (input valid, action, raw_sample, known_grams, output ready);
endinterface

// Result channel.
interface lcat_out_if
    import lcat_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight;
    logic [FACTOR_W-1:0]        scale_factor;
    logic                       zeroed;
    logic                       saturated;

    modport source (output valid, weight, scale_factor, zeroed, saturated, input ready);
    modport sink   (input valid, weight, scale_factor, zeroed, saturated, output ready);
endinterface

// Start-factor register write channel.
interface lcat_cfg_if
    import lcat_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FACTOR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/lcat_sdiv.sv]
// ----------------------------------------------------------------------------
// lcat_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module lcat_sdiv
    import lcat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // Bring down the next dividend bit and try the subtraction.
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];

    // Operand and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.dividend;
            den_reg  <= req.divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= req.steps;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

[hdl/lcat_ring.sv]
// ----------------------------------------------------------------------------
// lcat_ring
// Sample ring with write pointer, fill count and running sum of the window.
// ----------------------------------------------------------------------------
module lcat_ring
    import lcat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sample_t    sample,
    output ring_stat_t stat
);

    localparam int SUMX_W = SUM_W + 1;

    sample_t                 ring_mem [SAMPLES];
    logic [IDX_W-1:0]        wr_idx_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic signed [SUM_W-1:0] sum_reg;
    sample_t                 evict_reg;

    logic                    full;
    sample_t                 evicted;
    logic signed [SUMX_W-1:0] sum_ext;

    // Once the window is full, the entry being overwritten leaves the sum.
    assign full    = fill_reg == FILL_W'(SAMPLES);
    assign evicted = full ? evict_reg : '0;
    assign sum_ext = SUMX_W'(sum_reg) - SUMX_W'(evicted) + SUMX_W'(sample);

    // Sample storage. The entry under the write pointer is registered ahead
    // of the next push; pushes never come in consecutive cycles.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[wr_idx_reg] <= sample;
        end
        evict_reg <= ring_mem[wr_idx_reg];
    end

    // Pointer, fill count and running sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
        end
        else if (push)
        begin
            sum_reg <= sum_ext[SUM_W-1:0];
            if (wr_idx_reg == IDX_W'(SAMPLES - 1))
            begin
                wr_idx_reg <= '0;
            end
            else
            begin
                wr_idx_reg <= wr_idx_reg + IDX_W'(1);
            end
            if (!full)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    assign stat.sum  = sum_reg;
    assign stat.fill = fill_reg;

endmodule

[hdl/load_cell_average_tare_calibrate.sv]
// ----------------------------------------------------------------------------
// load_cell_average_tare_calibrate: a sample runs the average and then the weight
// division; a calibrate runs the factor division (skipped with zero mass) and then
// the weight division; a tare or no-op goes straight to the result. One transaction
// at a time: the next can be accepted in the cycle after the result is loaded.
// Reset: asynchronous active low; factor 65536, sums, offset and weight cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module load_cell_average_tare_calibrate
    import lcat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    lcat_in_if.sink    in_ch,
    lcat_out_if.source out_ch,
    lcat_cfg_if.sink   cfg_ch
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_AVG_START = 3'd1;
    localparam logic [2:0] S_AVG_WAIT  = 3'd2;
    localparam logic [2:0] S_CAL_START = 3'd3;
    localparam logic [2:0] S_CAL_WAIT  = 3'd4;
    localparam logic [2:0] S_WGT_START = 3'd5;
    localparam logic [2:0] S_WGT_WAIT  = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0]                 state_reg;
    sample_t                    avg_reg;
    sample_t                    offset_reg;
    logic                       offset_set_reg;
    logic [FACTOR_W-1:0]        factor_reg;
    logic [WEIGHT_W-1:0]        weight_reg;
    logic                       clipped_reg;
    logic [MASS_W-1:0]          mass_reg;
    logic                       neg_reg;
    logic                       out_valid_reg;
    logic signed [WEIGHT_W-1:0] out_weight_reg;
    logic [FACTOR_W-1:0]        out_factor_reg;
    logic                       out_zeroed_reg;
    logic                       out_sat_reg;

    ring_stat_t                 ring_stat;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic                       accept;
    logic                       out_load;
    logic [SUM_W-1:0]           sum_mag;
    logic signed [DIFF_W-1:0]   diff;
    logic [SAMPLE_W-1:0]        diff_mag;
    logic [NUM_W-1:0]           q;
    sample_t                    avg_new;
    logic                       pos_ovf;
    logic                       neg_ovf;
    logic [WEIGHT_W-1:0]        weight_new;
    logic                       cal_ok;
    logic [FACTOR_W-1:0]        factor_new;

    // Register writes are taken only between transactions.
    assign accept     = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = state_reg == S_IDLE;
    assign cfg_ch.ready = state_reg == S_IDLE;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    // Sample window storage.
    lcat_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && (in_ch.action == ACT_SAMPLE)),
        .sample (in_ch.raw_sample),
        .stat   (ring_stat)
    );

    // Shared serial divider.
    lcat_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Magnitudes of the running sum and of the net reading.
    assign sum_mag  = ring_stat.sum[SUM_W-1] ? SUM_W'(-ring_stat.sum) : ring_stat.sum;
    assign diff     = DIFF_W'(avg_reg) - DIFF_W'(offset_reg);
    assign diff_mag = diff[DIFF_W-1] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

    // Divider operands for each phase.
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_AVG_START:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = AVG_STEPS;
                div_req.dividend = {sum_mag, {(NUM_W - SUM_W){1'b0}}};
                div_req.divisor  = DEN_W'(ring_stat.fill);
            end
            S_CAL_START:
            begin
                div_req.start    = mass_reg != '0;
                div_req.steps    = DIV_STEPS;
                div_req.dividend = {diff_mag, {SCALE_SHIFT{1'b0}}};
                div_req.divisor  = DEN_W'(mass_reg);
            end
            S_WGT_START:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = DIV_STEPS;
                div_req.dividend = {diff_mag, {SCALE_SHIFT{1'b0}}};
                div_req.divisor  = factor_reg;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    // Signed results from the unsigned quotient, with clipping.
    assign q          = div_rsp.quotient;
    assign avg_new    = neg_reg ? sample_t'(-q[SAMPLE_W-1:0]) : sample_t'(q[SAMPLE_W-1:0]);
    assign pos_ovf    = |q[NUM_W-1:WEIGHT_W-1];
    assign neg_ovf    = (|q[NUM_W-1:WEIGHT_W]) || (q[WEIGHT_W-1] && (|q[WEIGHT_W-2:0]));
    assign weight_new = neg_reg ? (neg_ovf ? WEIGHT_MIN : WEIGHT_W'(-q[WEIGHT_W-1:0]))
                                : (pos_ovf ? WEIGHT_MAX : q[WEIGHT_W-1:0]);
    assign cal_ok     = !neg_reg && (q != '0);
    assign factor_new = (|q[NUM_W-1:FACTOR_W]) ? FACTOR_MAX : q[FACTOR_W-1:0];

    // Sequencer and conditioner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            avg_reg        <= '0;
            offset_reg     <= '0;
            offset_set_reg <= 1'b0;
            factor_reg     <= DEFAULT_FACTOR;
            weight_reg     <= '0;
            clipped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                factor_reg <= (cfg_ch.data != '0) ? cfg_ch.data : DEFAULT_FACTOR;
            end
            // The result stays valid until the receiver takes it.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        case (in_ch.action)
                            ACT_SAMPLE:
                            begin
                                state_reg <= S_AVG_START;
                            end
                            ACT_TARE:
                            begin
                                if (ring_stat.fill != '0)
                                begin
                                    offset_reg <= avg_reg;
                                end
                                weight_reg  <= '0;
                                clipped_reg <= 1'b0;
                                state_reg   <= S_OUT;
                            end
                            ACT_CALIB:
                            begin
                                state_reg <= S_CAL_START;
                            end
                            default:
                            begin
                                clipped_reg <= 1'b0;
                                state_reg   <= S_OUT;
                            end
                        endcase
                    end
                end
                S_AVG_START:
                begin
                    state_reg <= S_AVG_WAIT;
                end
                S_AVG_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        avg_reg <= avg_new;
                        // The first full window becomes the zero offset.
                        if (!offset_set_reg && (ring_stat.fill == FILL_W'(SAMPLES)))
                        begin
                            offset_reg     <= avg_new;
                            offset_set_reg <= 1'b1;
                        end
                        state_reg <= S_WGT_START;
                    end
                end
                S_CAL_START:
                begin
                    state_reg <= (mass_reg != '0) ? S_CAL_WAIT : S_WGT_START;
                end
                S_CAL_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (cal_ok)
                        begin
                            factor_reg <= factor_new;
                        end
                        state_reg <= S_WGT_START;
                    end
                end
                S_WGT_START:
                begin
                    state_reg <= S_WGT_WAIT;
                end
                S_WGT_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        weight_reg  <= weight_new;
                        clipped_reg <= neg_reg ? neg_ovf : pos_ovf;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Latched item fields and the sign of the current division.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mass_reg <= in_ch.known_grams;
        end
        if (state_reg == S_AVG_START)
        begin
            neg_reg <= ring_stat.sum[SUM_W-1];
        end
        else if ((state_reg == S_CAL_START) || (state_reg == S_WGT_START))
        begin
            neg_reg <= diff[DIFF_W-1];
        end
    end

    // Output register: holds a result while the next transaction is worked on.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_weight_reg <= weight_reg;
            out_factor_reg <= factor_reg;
            out_zeroed_reg <= offset_set_reg;
            out_sat_reg    <= clipped_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.weight       = out_weight_reg;
    assign out_ch.scale_factor = out_factor_reg;
    assign out_ch.zeroed       = out_zeroed_reg;
    assign out_ch.saturated    = out_sat_reg;

    // Assertions.
    `ASSERT_IMPLIES(a_div_done_in_wait, clk, rst_n, div_rsp.done,
        (state_reg == S_AVG_WAIT) || (state_reg == S_CAL_WAIT) || (state_reg == S_WGT_WAIT),
        "divider finished outside a wait state")
    `ASSERT_NEXT(a_accept_starts_work, clk, rst_n, accept, state_reg != S_IDLE,
        "accepted transaction did not start")
    `ASSERT_NEXT(a_cfg_factor_nonzero, clk, rst_n, cfg_ch.valid && cfg_ch.ready,
        factor_reg != '0, "factor is zero after a register write")
    `ASSERT_IMPLIES(a_out_from_seq, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == S_OUT, "result appeared without the output state")

endmodule
